### hw/rtl/pkfa_pkg.sv
// Shared constants and width helpers for the periodic key frequency analyzer.
package pkfa_pkg;

	localparam int KEY_MAX_DEF     = 16;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int ALPHABET_SIZE   = 26;
	localparam int QUEUE_DEPTH     = 4;

	localparam int LETTER_W  = 5;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int POS_W     = 4;
	localparam int PEAK_W    = 16;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLAIN_LETTER = 1'd1;

	localparam logic [CFG_W-1:0] KEY_LENGTH_RST   = 5'd5;
	localparam logic [CFG_W-1:0] PLAIN_LETTER_RST = 5'd4;

	localparam logic [LETTER_W-1:0] LAST_LETTER = 5'(ALPHABET_SIZE - 1);
	localparam logic [LETTER_W-1:0] ALPHA_CODE  = 5'(ALPHABET_SIZE);

	function automatic int col_width(input int key_max);
		return (key_max > 1) ? $clog2(key_max) : 1;
	endfunction

	function automatic int len_width(input int key_max);
		return ($clog2(key_max + 1) > CFG_W) ? $clog2(key_max + 1) : CFG_W;
	endfunction

endpackage

### hw/rtl/pkfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pkfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/pkfa_fifo.sv
// Small register queue between the letter front end and the histogram engine.
module pkfa_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pkfa_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != CNT_W'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### hw/rtl/pkfa_front.sv
// Front end: accepts letters, assigns each its key column and classifies it.
module pkfa_front #(
	parameter int KEY_MAX = pkfa_pkg::KEY_MAX_DEF,
	parameter int LEN_W   = pkfa_pkg::len_width(KEY_MAX),
	parameter int COL_W   = pkfa_pkg::col_width(KEY_MAX)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [LEN_W-1:0]                      klen,
	input  logic                                  clearing,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [pkfa_pkg::S_DATA_W-1:0]         s_tdata,  // [4:0] letter_code
	input  logic                                  s_tlast,  // last_letter
	output logic                                  q_valid,
	input  logic                                  q_ready,
	output logic [COL_W+pkfa_pkg::LETTER_W+1:0]   q_data
);

	logic [COL_W-1:0]              col_pos_q;
	logic [COL_W-1:0]              col_cur;
	logic [LEN_W-1:0]              col_inc;
	logic [pkfa_pkg::LETTER_W-1:0] letter;
	logic                          counted;
	logic                          accept;

	assign letter   = s_tdata[pkfa_pkg::LETTER_W-1:0];
	assign counted  = (letter < pkfa_pkg::ALPHA_CODE);
	assign s_tready = q_ready && !clearing;
	assign q_valid  = s_tvalid && !clearing;
	assign accept   = s_tvalid && s_tready;

	// A column left beyond a shortened key wraps to zero before counting.
	assign col_cur = (LEN_W'(col_pos_q) >= klen) ? '0 : col_pos_q;
	assign col_inc = LEN_W'(col_cur) + LEN_W'(1);

	// Queue entry, low to high: letter, column, counted flag, last flag.
	assign q_data = {s_tlast, counted, col_cur, letter};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
		end else if (accept) begin
			if (s_tlast || col_inc >= klen) begin
				col_pos_q <= '0;
			end else begin
				col_pos_q <= COL_W'(col_inc);
			end
		end
	end

endmodule

### hw/rtl/pkfa_back.sv
// Back end: histogram updates, end-of-message column scan and clearing.
module pkfa_back #(
	parameter int KEY_MAX     = pkfa_pkg::KEY_MAX_DEF,
	parameter int COUNT_WIDTH = pkfa_pkg::COUNT_WIDTH_DEF,
	parameter int LEN_W       = pkfa_pkg::len_width(KEY_MAX),
	parameter int COL_W       = pkfa_pkg::col_width(KEY_MAX)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [LEN_W-1:0]                    klen,
	input  logic [pkfa_pkg::LETTER_W-1:0]       plain,
	input  logic                                q_valid,
	output logic                                q_ready,
	input  logic [COL_W+pkfa_pkg::LETTER_W+1:0] q_data,
	output logic                                clearing,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pkfa_pkg::M_DATA_W-1:0]       m_tdata,  // [3:0] key_position, [8:4] key_letter, [24:9] peak_count
	output logic                                m_tlast   // last_key
);

	localparam int LW     = pkfa_pkg::LETTER_W;
	localparam int ADDR_W = COL_W + LW;
	localparam int DEPTH  = 1 << ADDR_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;

	logic [1:0] state_q;

	// Queue entry fields.
	logic [LW-1:0]    q_letter;
	logic [COL_W-1:0] q_col;
	logic             q_counted;
	logic             q_last;

	// Letter pipeline stage (RAM read data valid).
	logic              lv_s1;
	logic              lc_s1;
	logic              ll_s1;
	logic [ADDR_W-1:0] la_s1;

	// Previous-cycle write, for read-after-write forwarding.
	logic                   wr_v_q;
	logic [ADDR_W-1:0]      wr_a_q;
	logic [COUNT_WIDTH-1:0] wr_d_q;

	// Scan issue counters and scan stage.
	logic [COL_W-1:0]       scol_q;
	logic [LW-1:0]          slet_q;
	logic                   issue_done_q;
	logic                   sv_s1;
	logic                   slast_s1;
	logic [COL_W-1:0]       scol_s1;
	logic [LW-1:0]          slet_s1;
	logic [LW-1:0]          best_q;
	logic [COUNT_WIDTH-1:0] peak_q;
	logic [LEN_W-1:0]       klen_q;
	logic [LW-1:0]          plain_q;

	// Output register.
	logic                    out_valid_q;
	logic [pkfa_pkg::POS_W-1:0]  pos_q;
	logic [LW-1:0]           key_q;
	logic [pkfa_pkg::PEAK_W-1:0] peakout_q;
	logic                    lastkey_q;

	logic                   pop;
	logic                   emit;
	logic                   col_start_ok;
	logic                   issue;
	logic                   issue_last;
	logic                   hist_we;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [COUNT_WIDTH-1:0] rd_data;
	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic [COUNT_WIDTH-1:0] inc_cnt;
	logic                   take;
	logic [LW-1:0]          new_best;
	logic [COUNT_WIDTH-1:0] new_peak;
	logic                   col_end;
	logic                   load;
	logic [LW:0]            key_sum;
	logic [LW-1:0]          key_letter;
	logic [pkfa_pkg::PEAK_W-1:0] peak_sat;

	assign q_letter  = q_data[LW-1:0];
	assign q_col     = q_data[ADDR_W-1:LW];
	assign q_counted = q_data[ADDR_W];
	assign q_last    = q_data[ADDR_W+1];

	assign clearing = (state_q == ST_CLEAR);
	assign emit     = (state_q == ST_SCAN);

	// Stop popping once the last letter of a message is in the update stage.
	assign q_ready = (state_q == ST_RUN) && !(lv_s1 && ll_s1);
	assign pop     = q_valid && q_ready;

	// A new column starts only after the previous one has left the scan stage
	// and, if it will be reported, the output register is empty.
	assign col_start_ok = !sv_s1 &&
		(!emit || LEN_W'(scol_q) >= klen_q || !out_valid_q);
	assign issue = (state_q != ST_RUN) && !issue_done_q &&
		(slet_q != '0 || col_start_ok);
	assign issue_last = issue && slet_q == pkfa_pkg::LAST_LETTER &&
		scol_q == COL_W'(KEY_MAX - 1);

	// Histogram read-modify-write.
	assign cur_cnt = (wr_v_q && wr_a_q == la_s1) ? wr_d_q : rd_data;
	assign inc_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
	assign hist_we = lv_s1 && lc_s1;

	// Every scanned entry is zeroed as it is read.
	assign ram_we    = hist_we || sv_s1;
	assign ram_waddr = hist_we ? la_s1 : {scol_s1, slet_s1};
	assign ram_wdata = hist_we ? inc_cnt : '0;
	assign ram_re    = pop || issue;
	assign ram_raddr = pop ? {q_col, q_letter} : {scol_q, slet_q};

	pkfa_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	// Peak search: strict greater-than keeps the lowest letter on a tie.
	assign take     = (slet_s1 == '0) || (rd_data > peak_q);
	assign new_best = take ? slet_s1 : best_q;
	assign new_peak = take ? rd_data : peak_q;
	assign col_end  = sv_s1 && slet_s1 == pkfa_pkg::LAST_LETTER;
	assign load     = col_end && emit && LEN_W'(scol_s1) < klen_q;

	assign key_sum    = (LW+1)'(new_best) + (LW+1)'(pkfa_pkg::ALPHA_CODE) - (LW+1)'(plain_q);
	assign key_letter = (key_sum >= (LW+1)'(pkfa_pkg::ALPHA_CODE)) ?
		LW'(key_sum - (LW+1)'(pkfa_pkg::ALPHA_CODE)) : LW'(key_sum);
	assign peak_sat   = (new_peak > COUNT_WIDTH'({pkfa_pkg::PEAK_W{1'b1}})) ?
		{pkfa_pkg::PEAK_W{1'b1}} : pkfa_pkg::PEAK_W'(new_peak);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			lv_s1        <= 1'b0;
			sv_s1        <= 1'b0;
			wr_v_q       <= 1'b0;
			scol_q       <= '0;
			slet_q       <= '0;
			issue_done_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			lv_s1  <= pop;
			sv_s1  <= issue;
			wr_v_q <= ram_we;

			if (issue) begin
				if (slet_q == pkfa_pkg::LAST_LETTER) begin
					slet_q <= '0;
					scol_q <= issue_last ? '0 : scol_q + COL_W'(1);
				end else begin
					slet_q <= slet_q + LW'(1);
				end
				if (issue_last) begin
					issue_done_q <= 1'b1;
				end
			end

			case (state_q)
				ST_CLEAR, ST_SCAN: begin
					if (sv_s1 && slast_s1) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (lv_s1 && ll_s1) begin
						state_q      <= ST_SCAN;
						issue_done_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			lc_s1 <= q_counted;
			ll_s1 <= q_last;
			la_s1 <= {q_col, q_letter};
		end
		wr_a_q <= ram_waddr;
		wr_d_q <= ram_wdata;
		if (issue) begin
			scol_s1  <= scol_q;
			slet_s1  <= slet_q;
			slast_s1 <= issue_last;
		end
		if (sv_s1) begin
			best_q <= new_best;
			peak_q <= new_peak;
		end
		if (state_q == ST_RUN && lv_s1 && ll_s1) begin
			klen_q  <= klen;
			plain_q <= plain;
		end
		if (load) begin
			pos_q     <= pkfa_pkg::POS_W'(scol_s1);
			key_q     <= key_letter;
			peakout_q <= peak_sat;
			lastkey_q <= (LEN_W'(scol_s1) + LEN_W'(1) == klen_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(pkfa_pkg::M_DATA_W - pkfa_pkg::POS_W - LW - pkfa_pkg::PEAK_W){1'b0}},
		peakout_q, key_q, pos_q};
	assign m_tlast  = lastkey_q;

	a_no_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && issue))
		else $error("histogram read port claimed by letter update and scan together");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !out_valid_q)
		else $error("result loaded over a result not yet taken");

	a_last_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && lv_s1 && ll_s1) |=> (state_q == ST_SCAN))
		else $error("last letter did not start the column scan");

	a_no_letter_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> !lv_s1)
		else $error("letter update active while scanning or clearing");

endmodule

### hw/rtl/periodic_key_frequency_analyzer.sv
// Top level of the periodic key frequency analyzer.
//
// Letters stream in and are counted in the histogram of their key column; one letter
// is taken per cycle while the queue has room, sustained by a read-modify-write of the
// histogram RAM (registered read, forwarding of the previous write) behind a four-entry
// queue. The letter flagged last starts a scan of all KEY_MAX columns through the single
// RAM read port: each column's 26 counters are read in turn, then a turnaround, and the
// scan waits while the output is stalled. One result per column below key_length is
// sent, and every counter is zeroed as it is read. Letters of the next message queue up
// during the scan. After reset the same sweep clears the RAM; no letter is accepted
// meanwhile, configuration writes are. Counters saturate at their all-ones value.
module periodic_key_frequency_analyzer #(
	parameter int KEY_MAX     = pkfa_pkg::KEY_MAX_DEF,
	parameter int COUNT_WIDTH = pkfa_pkg::COUNT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pkfa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pkfa_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pkfa_pkg::S_DATA_W-1:0]    s_tdata,  // [4:0] letter_code
	input  logic                             s_tlast,  // last_letter
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pkfa_pkg::M_DATA_W-1:0]    m_tdata,  // [3:0] key_position, [8:4] key_letter,
	                                                   // [24:9] peak_count
	output logic                             m_tlast   // last_key
);

	localparam int LEN_W = pkfa_pkg::len_width(KEY_MAX);
	localparam int COL_W = pkfa_pkg::col_width(KEY_MAX);
	localparam int Q_W   = COL_W + pkfa_pkg::LETTER_W + 2;

	logic [pkfa_pkg::CFG_W-1:0]    key_length_q;
	logic [pkfa_pkg::CFG_W-1:0]    plain_letter_q;
	logic [LEN_W-1:0]              klen;
	logic [pkfa_pkg::LETTER_W-1:0] plain;
	logic                          clearing;
	logic                          fq_in_valid;
	logic                          fq_in_ready;
	logic [Q_W-1:0]                fq_in_data;
	logic                          fq_out_valid;
	logic                          fq_out_ready;
	logic [Q_W-1:0]                fq_out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q   <= pkfa_pkg::KEY_LENGTH_RST;
			plain_letter_q <= pkfa_pkg::PLAIN_LETTER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pkfa_pkg::REG_KEY_LENGTH:   key_length_q   <= cfg_data;
				pkfa_pkg::REG_PLAIN_LETTER: plain_letter_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A key length of zero acts as one; lengths beyond KEY_MAX are clipped.
	assign klen = (key_length_q == '0) ? LEN_W'(1) :
		(LEN_W'(key_length_q) > LEN_W'(KEY_MAX)) ? LEN_W'(KEY_MAX) : LEN_W'(key_length_q);
	assign plain = (plain_letter_q >= pkfa_pkg::ALPHA_CODE) ?
		plain_letter_q - pkfa_pkg::ALPHA_CODE : plain_letter_q;

	pkfa_front #(
		.KEY_MAX(KEY_MAX),
		.LEN_W  (LEN_W),
		.COL_W  (COL_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.klen    (klen),
		.clearing(clearing),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.q_valid (fq_in_valid),
		.q_ready (fq_in_ready),
		.q_data  (fq_in_data)
	);

	pkfa_fifo #(
		.WIDTH(Q_W),
		.DEPTH(pkfa_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fq_in_valid),
		.in_ready (fq_in_ready),
		.in_data  (fq_in_data),
		.out_valid(fq_out_valid),
		.out_ready(fq_out_ready),
		.out_data (fq_out_data)
	);

	pkfa_back #(
		.KEY_MAX    (KEY_MAX),
		.COUNT_WIDTH(COUNT_WIDTH),
		.LEN_W      (LEN_W),
		.COL_W      (COL_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.klen    (klen),
		.plain   (plain),
		.q_valid (fq_out_valid),
		.q_ready (fq_out_ready),
		.q_data  (fq_out_data),
		.clearing(clearing),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule
